[rtl/sld_pkg.sv]
package sld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned KIND_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFE;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hED;
  localparam logic [BYTE_W-1:0] NEWLINE     = 8'h0A;
  localparam logic [CNT_W-1:0]  EXTRA_LEN   = 17'd8;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 17'h1FFFF;

  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_FILL  = 3'd4,
    PH_TERM  = 3'd5
  } sld_phase_t;

  typedef struct packed {
    logic              has;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  index;
    logic              ok;
  } sld_res_t;

endpackage

[rtl/sld_in_if.sv]
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/sld_out_if.sv]
interface sld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [16:0] byte_index;
  logic        terminator_ok;

  modport source (
    output valid, output kind, output byte_value, output byte_index,
    output terminator_ok, input ready
  );
  modport sink (
    input valid, input kind, input byte_value, input byte_index,
    input terminator_ok, output ready
  );
endinterface

[rtl/sld_in_stage.sv]
module sld_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  sld_in_if.sink                  in_ch,
  input  logic                    take,
  output logic                    vld,
  output logic [sld_pkg::BYTE_W-1:0] data
);
  import sld_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [BYTE_W-1:0] data_r;

  assign in_ch.ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.valid && in_ch.ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.rx_byte;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

[rtl/sld_parser.sv]
module sld_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [sld_pkg::BYTE_W-1:0] rx_byte,
  output sld_pkg::sld_res_t          res
);
  import sld_pkg::*;

  sld_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] remaining_r, remaining_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] rem_dec;

  assign count_inc = (count_r < CNT_MAX) ? count_r + 1'b1 : count_r;
  assign rem_dec   = (remaining_r != '0) ? remaining_r - 1'b1 : remaining_r;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    count_nxt     = count_r;
    res           = '0;
    res.index     = count_r;
    unique case (phase_r)
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          phase_nxt = PH_LENLO;
          count_nxt = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LENLO: begin
        remaining_nxt = {{(CNT_W-BYTE_W){1'b0}}, rx_byte};
        phase_nxt     = PH_LENHI;
        res.has       = 1'b1;
        res.kind      = KIND_BYTE;
        res.value     = rx_byte;
        count_nxt     = count_inc;
      end
      PH_LENHI: begin
        if (rx_byte == NEWLINE) begin
          phase_nxt = PH_HUNT;
          res.has   = 1'b1;
          res.kind  = KIND_ABORT;
        end else begin
          remaining_nxt = {1'b0, rx_byte, remaining_r[BYTE_W-1:0]} + EXTRA_LEN;
          phase_nxt     = PH_FILL;
          res.has       = 1'b1;
          res.kind      = KIND_BYTE;
          res.value     = rx_byte;
          count_nxt     = count_inc;
        end
      end
      PH_FILL: begin
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_TERM;
        end
        res.has   = 1'b1;
        res.kind  = KIND_BYTE;
        res.value = rx_byte;
        count_nxt = count_inc;
      end
      PH_TERM: begin
        phase_nxt = PH_HUNT;
        res.has   = 1'b1;
        res.kind  = KIND_END;
        res.ok    = (rx_byte == NEWLINE);
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      remaining_r <= '0;
      count_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      count_r     <= count_nxt;
    end
  end

  a_abort_from_lenhi: assert property (@(posedge clk) disable iff (!rst_n)
    (res.has && res.kind == KIND_ABORT) |-> phase_r == PH_LENHI)
    else $error("abort result outside length high phase");

  a_fill_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FILL |-> remaining_r != '0)
    else $error("fill phase with nothing remaining");

  a_term_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_TERM) |=> phase_r == PH_HUNT)
    else $error("terminator did not return to hunt");

endmodule

[rtl/sld_out_stage.sv]
module sld_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sld_pkg::sld_res_t res,
  output logic              room,
  sld_out_if.source         out_ch
);
  import sld_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [KIND_W-1:0] kind_r;
  logic [BYTE_W-1:0] value_r;
  logic [CNT_W-1:0]  index_r;
  logic              ok_r;

  assign room = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = res.has;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.has) begin
      kind_r  <= res.kind;
      value_r <= res.value;
      index_r <= res.index;
      ok_r    <= res.ok;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.byte_value    = value_r;
  assign out_ch.byte_index    = index_r;
  assign out_ch.terminator_ok = ok_r;

endmodule

[rtl/sync_length_frame_deframer.sv]
// sync/length frame deframer
// in_ch carries one received serial byte per transfer (valid/ready). the
// block hunts for the sync pair fe ed, reads a two byte length, then expects
// length + 8 body bytes and a terminator byte.
// out_ch carries at most one result per input byte: a stored frame byte with
// its index (kind 0), a frame end with the terminator check (kind 1), or an
// abort when the length high byte is 0a (kind 2). sync bytes give no result.
// path: an input byte is held in the input register, then goes through the
// parse logic into the result register.
// throughput: one byte per cycle while out_ch.ready is high; the parse state
// machine updates once per byte.
// stall: while a result waits in the result register, the parser holds and the
// input register keeps one more byte, after which in_ch.ready drops.
// reset: rst_n (synchronous, active low) empties both registers and returns
// the parser to the sync hunt with length and count cleared.
module sync_length_frame_deframer (
  input  logic      clk,
  input  logic      rst_n,
  sld_in_if.sink    in_ch,
  sld_out_if.source out_ch
);
  import sld_pkg::*;

  logic              in_vld;
  logic [BYTE_W-1:0] in_data;
  logic              room;
  logic              adv;
  sld_res_t          res;

  assign adv = in_vld && room;

  sld_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (adv),
    .vld   (in_vld),
    .data  (in_data)
  );

  sld_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_data),
    .res     (res)
  );

  sld_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
